FILE: rtl/core/msb_first_bit_packer_unit_defines.svh
// Assertion macros for the MSB-first bit packer.
// Included by the RTL files that carry concurrent assertions; needs no package.
`ifndef MSB_FIRST_BIT_PACKER_UNIT_DEFINES_SVH
`define MSB_FIRST_BIT_PACKER_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while reset is high.
`define MBP_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("msb_first_bit_packer: same-cycle check failed");

// Next-cycle implication, disabled while reset is high.
`define MBP_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("msb_first_bit_packer: next-cycle check failed");

`endif

FILE: rtl/core/mbp_pkg.sv
// Package of the MSB-first bit packer: payload structs, codes, state type.
// Depends on nothing; used by mbp_ctrl, mbp_datapath and the top level.
`default_nettype none

package mbp_pkg;

  localparam int POS_W        = 13;
  localparam int ACCESS_BYTES = 5;
  localparam int CNT_W        = 3;

  localparam logic [1:0] KIND_APPEND  = 2'd0;
  localparam logic [1:0] KIND_EXTRACT = 2'd1;
  localparam logic [1:0] KIND_SET     = 2'd2;

  typedef struct packed {
    logic [1:0]       kind;
    logic [31:0]      data_word;
    logic [5:0]       num_bits;
    logic [POS_W-1:0] new_position;
  } in_item_t;

  typedef struct packed {
    logic [31:0] read_data;
    logic        overflow;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_DISPATCH,
    ST_APP_RD,
    ST_APP_WR,
    ST_EXT_RD,
    ST_EXT_FIN,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic clr_wr;
    logic load;
    logic app_wr;
    logic ext_rd;
    logic finish;
  } cmd_t;

  typedef struct packed {
    logic clear_done;
    logic go_app;
    logic go_ext;
    logic app_last;
    logic ext_last;
    logic out_free;
  } status_t;

endpackage

`default_nettype wire

FILE: rtl/core/mbp_ctrl.sv
// Controller of the MSB-first bit packer: sequences clearing and each transfer.
// Depends on mbp_pkg; drives the command struct of mbp_datapath.
`default_nettype none

module mbp_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  input  mbp_pkg::status_t status,
  output logic            req_stall,
  output mbp_pkg::cmd_t   cmd
);
  import mbp_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_CLEAR: begin
        if (status.clear_done) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) state_next = ST_DISPATCH;
      end
      ST_DISPATCH: begin
        priority if (status.go_app) state_next = ST_APP_RD;
        else if (status.go_ext) state_next = ST_EXT_RD;
        else state_next = ST_DONE;
      end
      ST_APP_RD: state_next = ST_APP_WR;
      ST_APP_WR: begin
        if (status.app_last) state_next = ST_DONE;
      end
      ST_EXT_RD: begin
        if (status.ext_last) state_next = ST_EXT_FIN;
      end
      ST_EXT_FIN: state_next = ST_DONE;
      ST_DONE: begin
        if (status.out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    req_stall = 1'b1;
    unique case (state)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        req_stall = 1'b0;
        cmd.load  = req_valid;
      end
      ST_APP_WR: cmd.app_wr = 1'b1;
      ST_EXT_RD: cmd.ext_rd = 1'b1;
      ST_DONE:   cmd.finish = status.out_free;
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/core/mbp_datapath.sv
// Datapath of the MSB-first bit packer: byte store, positions, bit alignment.
// Depends on mbp_pkg and msb_first_bit_packer_unit_defines.svh; driven by mbp_ctrl.
`default_nettype none
`include "msb_first_bit_packer_unit_defines.svh"

module mbp_datapath #(
  parameter int STORE_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  mbp_pkg::in_item_t  req,
  input  mbp_pkg::cmd_t      cmd,
  input  logic               rsp_stall,
  output mbp_pkg::status_t   status,
  output logic               rsp_valid,
  output mbp_pkg::out_item_t rsp
);
  import mbp_pkg::*;

  localparam int CAP_BITS = STORE_BYTES * 8;
  localparam int PW = $clog2(CAP_BITS + 1);
  localparam int AW = $clog2(STORE_BYTES);
  localparam int XW = $clog2(STORE_BYTES + ACCESS_BYTES);
  localparam int CW = ((PW > POS_W) ? PW : POS_W) + 1;

  in_item_t         item;
  logic [PW-1:0]    wpos;
  logic [PW-1:0]    rpos;
  logic [CNT_W-1:0] cnt;
  logic [AW-1:0]    clr_addr;
  logic [7:0]       mem [STORE_BYTES];
  logic [7:0]       rdata;
  logic             cap;
  logic             cap_oob;
  logic [39:0]      acc;

  logic [5:0]    n_eff;
  logic          is_app;
  logic          is_ext;
  logic          is_set;
  logic [PW-1:0] cur_pos;
  logic [2:0]    off;
  logic [PW:0]   end_pos;
  logic          acc_ovf;
  logic          set_ovf;
  logic          ovf_hit;
  logic [31:0]   mask;
  logic [5:0]    span;
  logic [5:0]    shamt;
  logic [39:0]   wwin;
  logic [2:0]    nbytes;
  logic [XW-1:0] addr_x;
  logic          oob;
  logic [7:0]    wb;
  logic [7:0]    wdata;
  logic          we;
  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [39:0]   ext_shift;
  logic [31:0]   extracted;

  always_comb begin
    n_eff   = (item.num_bits > 6'd32) ? 6'd32 : item.num_bits;
    is_app  = (item.kind == KIND_APPEND) && (n_eff != 6'd0);
    is_ext  = (item.kind == KIND_EXTRACT) && (n_eff != 6'd0);
    is_set  = (item.kind == KIND_SET);
    cur_pos = is_app ? wpos : rpos;
    off     = cur_pos[2:0];
    end_pos = {1'b0, cur_pos} + (PW+1)'(n_eff);
    acc_ovf = end_pos > (PW+1)'(CAP_BITS);
    set_ovf = CW'(item.new_position) > CW'(CAP_BITS);
    ovf_hit = ((is_app || is_ext) && acc_ovf) || (is_set && set_ovf);
    mask    = 32'hFFFF_FFFF >> (6'd32 - n_eff);
    span    = {3'b000, off} + n_eff;
    shamt   = 6'd40 - span;
    wwin    = {8'h00, item.data_word & mask} << shamt;
    nbytes  = ((off != 3'd0) && (span <= 6'd8)) ? 3'd2 : 3'((span + 6'd7) >> 3);
    addr_x  = XW'(cur_pos[PW-1:3]) + XW'(cnt);
    oob     = addr_x >= XW'(STORE_BYTES);
    ext_shift = acc >> shamt;
    extracted = ext_shift[31:0] & mask;
  end

  always_comb begin
    unique case (cnt)
      3'd0:    wb = wwin[39:32];
      3'd1:    wb = wwin[31:24];
      3'd2:    wb = wwin[23:16];
      3'd3:    wb = wwin[15:8];
      3'd4:    wb = wwin[7:0];
      default: wb = 8'h00;
    endcase
  end

  always_comb begin
    wdata = cmd.clr_wr ? 8'h00 : wb;
    if (!cmd.clr_wr && (cnt == '0) && (off != 3'd0)) begin
      wdata = wb | rdata;
    end
    we    = cmd.clr_wr || (cmd.app_wr && !oob);
    waddr = cmd.clr_wr ? clr_addr : addr_x[AW-1:0];
    raddr = oob ? '0 : addr_x[AW-1:0];
  end

  always_comb begin
    status.clear_done = (clr_addr == AW'(STORE_BYTES - 1));
    status.go_app     = is_app && !acc_ovf;
    status.go_ext     = is_ext && !acc_ovf;
    status.app_last   = (cnt == (nbytes - 3'd1));
    status.ext_last   = (cnt == CNT_W'(ACCESS_BYTES - 1));
    status.out_free   = !rsp_valid || !rsp_stall;
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wpos      <= '0;
      rpos      <= '0;
      clr_addr  <= '0;
      cnt       <= '0;
      cap       <= 1'b0;
      rsp_valid <= 1'b0;
    end else begin
      cap <= cmd.ext_rd;
      if (cmd.clr_wr) begin
        clr_addr <= clr_addr + AW'(1);
      end
      if (cmd.load) begin
        cnt <= '0;
      end else if (cmd.app_wr || cmd.ext_rd) begin
        cnt <= cnt + CNT_W'(1);
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
        if (!ovf_hit) begin
          if (is_app) wpos <= wpos + PW'(n_eff);
          if (is_set) wpos <= PW'(item.new_position);
          if (is_ext) rpos <= rpos + PW'(n_eff);
        end
      end else if (rsp_valid && !rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cap_oob <= oob;
    if (cmd.load) begin
      item <= req;
    end
    if (cap) begin
      acc <= {acc[31:0], (cap_oob ? 8'h00 : rdata)};
    end
    if (cmd.finish) begin
      rsp.read_data <= (is_ext && !ovf_hit) ? extracted : 32'd0;
      rsp.overflow  <= ovf_hit;
    end
  end

  `MBP_ASSERT_IMPLY(a_wpos_range, clk, rst, 1'b1, ({1'b0, wpos} <= (PW+1)'(CAP_BITS)))
  `MBP_ASSERT_IMPLY(a_rpos_range, clk, rst, 1'b1, ({1'b0, rpos} <= (PW+1)'(CAP_BITS)))
  `MBP_ASSERT_IMPLY(a_app_cnt, clk, rst, cmd.app_wr, (cnt < CNT_W'(ACCESS_BYTES)))
  `MBP_ASSERT_NEXT(a_ovf_hold, clk, rst, (cmd.finish && ovf_hit), ($stable(wpos) && $stable(rpos)))

endmodule

`default_nettype wire

FILE: rtl/core/msb_first_bit_packer_unit.sv
// Top level of the MSB-first bit packer: joins controller and datapath.
// Depends on mbp_pkg, mbp_ctrl and mbp_datapath.
//
// After reset the block clears its byte store, one byte a cycle, and holds req_stall high
// meanwhile. The store has one byte-wide write port and one byte-wide read port, and each
// transfer is worked through a byte at a time: a set, an ignored access or an unused kind
// goes from dispatch straight to done, an append reads its first byte and then writes each
// byte it touches, and an extract reads all five bytes of its window. The result waits in an
// output register, so a new request is taken while the previous result is still stalled.
`default_nettype none

module msb_first_bit_packer_unit #(
  parameter int STORE_BYTES = 512
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  mbp_pkg::in_item_t  req,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output mbp_pkg::out_item_t rsp
);
  import mbp_pkg::*;

  cmd_t    cmd;
  status_t status;

  mbp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .status    (status),
    .req_stall (req_stall),
    .cmd       (cmd)
  );

  mbp_datapath #(
    .STORE_BYTES (STORE_BYTES)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .cmd       (cmd),
    .rsp_stall (rsp_stall),
    .status    (status),
    .rsp_valid (rsp_valid),
    .rsp       (rsp)
  );

endmodule

`default_nettype wire
